// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define SA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define SA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/salloc_pkg.sv =====
// Package for the LIFO stack allocator: sizes, command and status codes, and the
// structs passed between the allocator modules. No dependencies.
`timescale 1ns / 1ps

package salloc_pkg;

    // Byte area and chunk geometry (ELEM_BYTES must be a power of two)
    localparam int CAPACITY_BYTES = 4096;
    localparam int ELEM_BYTES     = 4;
    localparam int MAX_CHUNKS     = 1024;
    localparam int ELEM_SHIFT     = $clog2(ELEM_BYTES);

    // Field and state widths
    localparam int CMD_W   = 2;
    localparam int SIZE_W  = 13;
    localparam int OFF_W   = 12;
    localparam int TOP_W   = 13;
    localparam int COUNT_W = $clog2(MAX_CHUNKS) + 1;
    localparam int IDX_W   = $clog2(MAX_CHUNKS);
    localparam int ROUND_W = SIZE_W + 1;
    localparam int SUM_W   = ROUND_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOMEM  = 2'd1,
        ST_ORDER  = 2'd2,
        ST_BADPTR = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t              command;
        logic [SIZE_W-1:0] size_bytes;
        logic [OFF_W-1:0]  chunk_offset;
    } item_t;

    typedef struct packed {
        logic [OFF_W-1:0] address;
        status_t          status;
        logic [TOP_W-1:0] bytes_used;
    } result_t;

    // Size store access issued by the core each cycle
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [TOP_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

// ===== rtl/salloc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents when the same address is written. No dependencies.
`timescale 1ns / 1ps

module salloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/salloc_core.sv =====
// Allocator core: stack top and chunk count, command decode, result register.
// Depends on salloc_pkg; drives the size store held in salloc_ram.
`timescale 1ns / 1ps

module salloc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  salloc_pkg::item_t           item,
    input  logic [salloc_pkg::TOP_W-1:0] ram_rdata,
    output salloc_pkg::ram_req_t        ram_req,
    output logic                        done,
    output salloc_pkg::result_t         result
);

    localparam int TOP_W   = salloc_pkg::TOP_W;
    localparam int COUNT_W = salloc_pkg::COUNT_W;
    localparam int IDX_W   = salloc_pkg::IDX_W;
    localparam int ROUND_W = salloc_pkg::ROUND_W;
    localparam int SUM_W   = salloc_pkg::SUM_W;
    localparam int OFF_W   = salloc_pkg::OFF_W;

    logic [TOP_W-1:0]   stack_top_reg, stack_top_next;
    logic [COUNT_W-1:0] chunk_count_reg, chunk_count_next;
    logic               bypass_valid_reg, bypass_valid_next;
    logic [TOP_W-1:0]   bypass_size_reg, bypass_size_next;
    logic               done_reg, done_next;
    salloc_pkg::result_t result_reg, result_next;

    logic [ROUND_W-1:0] rounded;
    logic [SUM_W-1:0]   alloc_need;
    logic [TOP_W-1:0]   data_addr;
    logic [TOP_W-1:0]   top_size;
    logic [TOP_W-1:0]   off_ext;
    logic [TOP_W-1:0]   top_data;
    logic               no_room;
    logic               bad_ptr;
    logic [COUNT_W-1:0] count_minus1;

    // Size of the top chunk: a push in the previous cycle is not yet visible in the RAM read
    assign top_size = bypass_valid_reg ? bypass_size_reg : ram_rdata;

    // Allocate arithmetic: round up, then header plus chunk on top of the stack
    assign rounded = ({1'b0, item.size_bytes} + ROUND_W'(salloc_pkg::ELEM_BYTES - 1))
                     & ~ROUND_W'(salloc_pkg::ELEM_BYTES - 1);
    assign alloc_need = {{(SUM_W-TOP_W){1'b0}}, stack_top_reg}
                        + SUM_W'(salloc_pkg::ELEM_BYTES) + {1'b0, rounded};
    assign data_addr = stack_top_reg + TOP_W'(salloc_pkg::ELEM_BYTES);
    assign no_room   = (chunk_count_reg >= COUNT_W'(salloc_pkg::MAX_CHUNKS))
                       || (alloc_need > SUM_W'(salloc_pkg::CAPACITY_BYTES));

    // Free checks: pointer inside the live area and aligned, then top-of-stack match
    assign off_ext  = {1'b0, item.chunk_offset};
    assign bad_ptr  = (chunk_count_reg == '0)
                      || (item.chunk_offset < OFF_W'(salloc_pkg::ELEM_BYTES))
                      || ((off_ext - TOP_W'(salloc_pkg::ELEM_BYTES)) >= stack_top_reg)
                      || (item.chunk_offset[salloc_pkg::ELEM_SHIFT-1:0] != '0);
    assign top_data = stack_top_reg - top_size;
    assign count_minus1 = chunk_count_next - COUNT_W'(1);

    // Decode the command, update the stack and form the result
    always_comb
    begin
        stack_top_next    = stack_top_reg;
        chunk_count_next  = chunk_count_reg;
        bypass_valid_next = 1'b0;
        bypass_size_next  = bypass_size_reg;
        done_next         = item_valid;
        result_next       = result_reg;
        ram_req.we        = 1'b0;
        ram_req.waddr     = chunk_count_reg[IDX_W-1:0];
        ram_req.wdata     = rounded[TOP_W-1:0];

        if (item_valid)
        begin
            result_next.address = '0;
            result_next.status  = salloc_pkg::ST_OK;
            case (item.command)
                salloc_pkg::CMD_ALLOC:
                begin
                    if (no_room)
                    begin
                        result_next.status = salloc_pkg::ST_NOMEM;
                    end
                    else
                    begin
                        result_next.address = data_addr[OFF_W-1:0];
                        ram_req.we          = 1'b1;
                        chunk_count_next    = chunk_count_reg + COUNT_W'(1);
                        stack_top_next      = alloc_need[TOP_W-1:0];
                        bypass_valid_next   = 1'b1;
                        bypass_size_next    = rounded[TOP_W-1:0];
                    end
                end
                salloc_pkg::CMD_FREE:
                begin
                    if (bad_ptr)
                    begin
                        result_next.status = salloc_pkg::ST_BADPTR;
                    end
                    else if (off_ext != top_data)
                    begin
                        result_next.status = salloc_pkg::ST_ORDER;
                    end
                    else
                    begin
                        chunk_count_next = chunk_count_reg - COUNT_W'(1);
                        stack_top_next   = top_data - TOP_W'(salloc_pkg::ELEM_BYTES);
                    end
                end
                salloc_pkg::CMD_RESET:
                begin
                    chunk_count_next = '0;
                    stack_top_next   = '0;
                end
                salloc_pkg::CMD_NOP:
                begin
                    stack_top_next = stack_top_reg;
                end
                default:
                begin
                    stack_top_next = stack_top_reg;
                end
            endcase
            result_next.bytes_used = stack_top_next;
        end

        // Fetch the size of the chunk that will be on top next cycle
        ram_req.raddr = count_minus1[IDX_W-1:0];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_top_reg    <= '0;
            chunk_count_reg  <= '0;
            bypass_valid_reg <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            stack_top_reg    <= stack_top_next;
            chunk_count_reg  <= chunk_count_next;
            bypass_valid_reg <= bypass_valid_next;
            done_reg         <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bypass_size_reg <= bypass_size_next;
        result_reg      <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/stack_allocator.sv =====
// Top level of the LIFO stack allocator: input register, core and chunk size RAM.
// Depends on salloc_pkg, salloc_core, salloc_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One command (allocate, free, reset, no-op) is taken on each clock edge with start high;
// busy never rises, so a command may be issued every cycle. The result appears
// after the input register and the result register, on address, status and
// bytes_used with done high for exactly one cycle, and must be captured then: there
// is no way to hold it. The chunk size store is a 1024-entry RAM whose read
// address follows the updated chunk count, so it fetches the next top chunk's size.
// No clearing pass is needed after reset.
module stack_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [salloc_pkg::CMD_W-1:0]  command,
    input  logic [salloc_pkg::SIZE_W-1:0] size_bytes,
    input  logic [salloc_pkg::OFF_W-1:0]  chunk_offset,
    output logic                          done,
    output logic [salloc_pkg::OFF_W-1:0]  address,
    output logic [1:0]                    status,
    output logic [salloc_pkg::TOP_W-1:0]  bytes_used
);

    logic                         item_valid_reg;
    salloc_pkg::item_t            item_reg;
    salloc_pkg::ram_req_t         ram_req;
    logic [salloc_pkg::TOP_W-1:0] ram_rdata;
    salloc_pkg::result_t          result;

    // Every cycle is open for a new command
    assign busy = 1'b0;

    // Input register: hold the command for the core
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg.command      <= salloc_pkg::cmd_t'(command);
            item_reg.size_bytes   <= size_bytes;
            item_reg.chunk_offset <= chunk_offset;
        end
    end

    salloc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .ram_rdata  (ram_rdata),
        .ram_req    (ram_req),
        .done       (done),
        .result     (result)
    );

    salloc_ram #(
        .WIDTH (salloc_pkg::TOP_W),
        .DEPTH (salloc_pkg::MAX_CHUNKS)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign address    = result.address;
    assign status     = result.status;
    assign bytes_used = result.bytes_used;

    // Every registered transfer yields exactly one result strobe, and no strobe comes without one
    `SA_ASSERT_NEXT(a_result_follows, item_valid_reg, done, "result strobe missing after transfer")
    `SA_ASSERT_NEXT(a_no_stray_result, !item_valid_reg, !done, "result strobe without transfer")
    // Stack never grows past the byte area
    `SA_ASSERT(a_top_in_range, !done || (bytes_used <= salloc_pkg::TOP_W'(salloc_pkg::CAPACITY_BYTES)), "bytes in use exceed capacity")
    // A nonzero address is only handed out by a successful allocate
    `SA_ASSERT(a_addr_only_ok, !done || (address == '0) || (status == salloc_pkg::ST_OK), "address returned with failure status")

endmodule
